@@ sv/frac_pkg.sv @@
// ----------------------------------------------------------------------------
// Fraction reducer package
// Widths shared by the interfaces, the divider and the top level.
// ----------------------------------------------------------------------------
package frac_pkg;

  localparam int FIELD_BITS         = 16;
  localparam int DEFAULT_VALUE_BITS = 16;

endpackage

@@ sv/frac_if.sv @@
// ----------------------------------------------------------------------------
// Fraction reducer channels
// Valid/ready channels for the input fraction and the reduced fraction.
// ----------------------------------------------------------------------------
interface frac_in_if import frac_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] num_in;
  logic signed [FIELD_BITS-1:0] den_in;

  modport source (output valid, output num_in, output den_in, input ready);
  modport sink (input valid, input num_in, input den_in, output ready);
endinterface

interface frac_out_if import frac_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] num_out;
  logic signed [FIELD_BITS-1:0] den_out;

  modport source (output valid, output num_out, output den_out, input ready);
  modport sink (input valid, input num_out, input den_out, output ready);
endinterface

@@ sv/frac_div_pipe.sv @@
// ----------------------------------------------------------------------------
// Fraction reducer divider
// Pipelined restoring divider, one quotient bit per stage, W stages.
// ----------------------------------------------------------------------------
module frac_div_pipe import frac_pkg::*; #(
  parameter int W = DEFAULT_VALUE_BITS
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient
);

  logic [W-1:0] rem [0:W];
  logic [W-1:0] nq  [0:W];
  logic [W-1:0] dv  [0:W];

  assign rem[0]   = '0;
  assign nq[0]    = dividend;
  assign dv[0]    = divisor;
  assign quotient = nq[W];

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W:0] trial;
    assign trial = {rem[i], nq[i][W-1]} - {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= dv[i];
        if (!trial[W]) begin
          rem[i+1] <= trial[W-1:0];
          nq[i+1]  <= {nq[i][W-2:0], 1'b1};
        end else begin
          rem[i+1] <= {rem[i][W-2:0], nq[i][W-1]};
          nq[i+1]  <= {nq[i][W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

@@ sv/fraction_reducer.sv @@
// ----------------------------------------------------------------------------
// Fraction reducer
// Reduces a signed fraction to lowest terms through its GCD when both terms share a sign.
// ----------------------------------------------------------------------------
// A word enters every cycle while the output side takes words; each word passes
// through an input register, the binary GCD pipeline (2*VALUE_BITS steps), a
// register that forms the GCD, the restoring divider (VALUE_BITS steps) and an
// output register.
// When both values are nonzero and share a sign, both are divided by the
// GCD of their magnitudes; otherwise they pass through unchanged.
module fraction_reducer import frac_pkg::*; #(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input logic   clk,
  input logic   rst,
  frac_in_if.sink    req,
  frac_out_if.source rsp
);

  localparam int W  = VALUE_BITS;
  localparam int S  = 2 * VALUE_BITS;
  localparam int KW = $clog2(VALUE_BITS + 1);

  function automatic logic [W-1:0] from_field(input logic [FIELD_BITS-1:0] f);
    logic [W-1:0] r;
    r = '0;
    for (int i = 0; i < W; i++) begin
      if (i < FIELD_BITS) r[i] = f[i];
    end
    return r;
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input logic [W-1:0] x);
    logic [FIELD_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (i < W) r[i] = x[i];
    end
    return r;
  endfunction

  logic en;
  logic out_valid;
  logic [FIELD_BITS-1:0] out_num;
  logic [FIELD_BITS-1:0] out_den;

  assign en          = !out_valid || rsp.ready;
  assign req.ready   = en;
  assign rsp.valid   = out_valid;
  assign rsp.num_out = out_num;
  assign rsp.den_out = out_den;

  logic [W-1:0] in_n;
  logic [W-1:0] in_d;
  assign in_n = from_field(req.num_in);
  assign in_d = from_field(req.den_in);

  logic          gv   [0:S];
  logic [W-1:0]  grn  [0:S];
  logic [W-1:0]  grd  [0:S];
  logic          gred [0:S];
  logic          gneg [0:S];
  logic [W-1:0]  gmn  [0:S];
  logic [W-1:0]  gmd  [0:S];
  logic [W-1:0]  ga   [0:S];
  logic [W-1:0]  gb   [0:S];
  logic [KW-1:0] gk   [0:S];

  always_ff @(posedge clk) begin
    if (rst) begin
      gv[0] <= 1'b0;
    end else if (en) begin
      gv[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grn[0]  <= in_n;
      grd[0]  <= in_d;
      gred[0] <= (in_n != '0) && (in_d != '0) && (in_n[W-1] == in_d[W-1]);
      gneg[0] <= in_n[W-1];
      gmn[0]  <= in_n[W-1] ? W'(-in_n) : in_n;
      gmd[0]  <= in_d[W-1] ? W'(-in_d) : in_d;
      ga[0]   <= in_n[W-1] ? W'(-in_n) : in_n;
      gb[0]   <= in_d[W-1] ? W'(-in_d) : in_d;
      gk[0]   <= '0;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_gcd
    always_ff @(posedge clk) begin
      if (rst) begin
        gv[i+1] <= 1'b0;
      end else if (en) begin
        gv[i+1] <= gv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        grn[i+1]  <= grn[i];
        grd[i+1]  <= grd[i];
        gred[i+1] <= gred[i];
        gneg[i+1] <= gneg[i];
        gmn[i+1]  <= gmn[i];
        gmd[i+1]  <= gmd[i];
        ga[i+1]   <= ga[i];
        gb[i+1]   <= gb[i];
        gk[i+1]   <= gk[i];
        priority if (ga[i] == '0 || gb[i] == '0) begin
        end else if (!ga[i][0] && !gb[i][0]) begin
          ga[i+1] <= ga[i] >> 1;
          gb[i+1] <= gb[i] >> 1;
          gk[i+1] <= KW'(gk[i] + 1'b1);
        end else if (!ga[i][0]) begin
          ga[i+1] <= ga[i] >> 1;
        end else if (!gb[i][0]) begin
          gb[i+1] <= gb[i] >> 1;
        end else if (ga[i] >= gb[i]) begin
          ga[i+1] <= W'(ga[i] - gb[i]) >> 1;
        end else begin
          gb[i+1] <= W'(gb[i] - ga[i]) >> 1;
        end
      end
    end
  end

  logic         dv   [0:W];
  logic [W-1:0] drn  [0:W];
  logic [W-1:0] drd  [0:W];
  logic         dred [0:W];
  logic         dneg [0:W];
  logic [W-1:0] div_mn;
  logic [W-1:0] div_md;
  logic [W-1:0] div_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= gv[S];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drn[0]  <= grn[S];
      drd[0]  <= grd[S];
      dred[0] <= gred[S];
      dneg[0] <= gneg[S];
      div_mn  <= gmn[S];
      div_md  <= gmd[S];
      div_g   <= (ga[S] | gb[S]) << gk[S];
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (en) begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drn[i+1]  <= drn[i];
        drd[i+1]  <= drd[i];
        dred[i+1] <= dred[i];
        dneg[i+1] <= dneg[i];
      end
    end
  end

  logic [W-1:0] qn;
  logic [W-1:0] qd;

  frac_div_pipe #(.W(W)) u_div_num (
    .clk      (clk),
    .en       (en),
    .dividend (div_mn),
    .divisor  (div_g),
    .quotient (qn)
  );

  frac_div_pipe #(.W(W)) u_div_den (
    .clk      (clk),
    .en       (en),
    .dividend (div_md),
    .divisor  (div_g),
    .quotient (qd)
  );

  logic [W-1:0] res_n;
  logic [W-1:0] res_d;

  always_comb begin
    if (dred[W]) begin
      res_n = dneg[W] ? W'(-qn) : qn;
      res_d = dneg[W] ? W'(-qd) : qd;
    end else begin
      res_n = drn[W];
      res_d = drd[W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_num <= to_field(res_n);
      out_den <= to_field(res_d);
    end
  end

endmodule
